// ----- hw/rtl/cnlw_pkg.sv -----
// ----------------------------------------------------------------------------
// cnlw_pkg
// types, register map and constants shared by the lcd nibble write sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cnlw_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_DATA    = 2'd2,
      OP_INIT    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_POWERUP = 3'd1,
      PH_HI_EN   = 3'd2,
      PH_HI_SET  = 3'd3,
      PH_LO_EN   = 3'd4,
      PH_LO_SET  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] value_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] bus_nibble;
      logic       reg_select;
      logic       enable_line;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   localparam int CFG_BITS   = 10;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;
   localparam int INIT_COUNT = 5;

   typedef struct packed {
      logic [CFG_BITS-1:0] enable_high_ticks;
      logic [CFG_BITS-1:0] command_settle_ticks;
      logic [CFG_BITS-1:0] data_settle_ticks;
      logic [CFG_BITS-1:0] powerup_ticks;
   } cfg_type;

   localparam logic [1:0] REG_ENABLE_HIGH    = 2'd0;
   localparam logic [1:0] REG_COMMAND_SETTLE = 2'd1;
   localparam logic [1:0] REG_DATA_SETTLE    = 2'd2;
   localparam logic [1:0] REG_POWERUP        = 2'd3;

   localparam logic [CFG_BITS-1:0] ENABLE_HIGH_RESET    = 10'd1;
   localparam logic [CFG_BITS-1:0] COMMAND_SETTLE_RESET = 10'd5;
   localparam logic [CFG_BITS-1:0] DATA_SETTLE_RESET    = 10'd2;
   localparam logic [CFG_BITS-1:0] POWERUP_RESET        = 10'd50;

   // fixed init command sequence, register select low
   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      unique case (idx)
         3'd0:    cmd = 8'h02;
         3'd1:    cmd = 8'h28;
         3'd2:    cmd = 8'h0E;
         3'd3:    cmd = 8'h01;
         3'd4:    cmd = 8'h80;
         default: cmd = 8'h00;
      endcase
      return cmd;
   endfunction

endpackage

// ----- hw/rtl/char_lcd_nibble_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// The block takes one item per cycle while req_stall is low (a tick, a command
// byte, a data byte or an init request) and returns one item per input item with
// the display pin state after that item; throughput is one item per clock while
// the downstream does not stall. Items pass the input register and then the
// result register, with the phase machine and delay counter updated between
// them. A full result register stalls the input side only when the downstream
// stalls. The user must write timing registers over the csr port only while the
// block is idle, which it does not enforce; they take effect at the next time load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer #(
   parameter int DELAY_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cnlw_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cnlw_pkg::rsp_type              rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cnlw_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [cnlw_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [cnlw_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cnlw_pkg::*;

   cfg_type cfg;
   req_type s1_item_ff, s1_item_in;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type core_result;
   logic    out_free;
   logic    advance;
   logic    accept;

   cnlw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cnlw_core #(
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign s1_item_in   = accept ? req_payload : s1_item_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = advance ? core_result : rsp_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ----- hw/rtl/cnlw_csr.sv -----
// ----------------------------------------------------------------------------
// cnlw_csr
// apb-style register file holding the four timing registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cnlw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cnlw_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [cnlw_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [cnlw_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output cnlw_pkg::cfg_type             cfg
);
   import cnlw_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;
   logic [CFG_BITS-1:0] wdata;
   logic [CFG_BITS-1:0] rdata;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];
   assign wdata      = csr_pwdata[CFG_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_ENABLE_HIGH:    cfg_in.enable_high_ticks    = wdata;
            REG_COMMAND_SETTLE: cfg_in.command_settle_ticks = wdata;
            REG_DATA_SETTLE:    cfg_in.data_settle_ticks    = wdata;
            REG_POWERUP:        cfg_in.powerup_ticks        = wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ENABLE_HIGH:    rdata = cfg_ff.enable_high_ticks;
         REG_COMMAND_SETTLE: rdata = cfg_ff.command_settle_ticks;
         REG_DATA_SETTLE:    rdata = cfg_ff.data_settle_ticks;
         REG_POWERUP:        rdata = cfg_ff.powerup_ticks;
         default:            rdata = '0;
      endcase
   end

   assign csr_prdata = DATA_BITS'(rdata);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_high_ticks    <= ENABLE_HIGH_RESET;
         cfg_ff.command_settle_ticks <= COMMAND_SETTLE_RESET;
         cfg_ff.data_settle_ticks    <= DATA_SETTLE_RESET;
         cfg_ff.powerup_ticks        <= POWERUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/cnlw_core.sv -----
// ----------------------------------------------------------------------------
// cnlw_core
// phase machine, delay counter and pin state; one item updates it per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cnlw_core #(
   parameter int DELAY_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  cnlw_pkg::req_type item,
   input  cnlw_pkg::cfg_type cfg,
   output cnlw_pkg::rsp_type result
);
   import cnlw_pkg::*;

   localparam int CW = (DELAY_BITS > CFG_BITS) ? DELAY_BITS : CFG_BITS;
   localparam logic [DELAY_BITS-1:0] CNT_MAX = {DELAY_BITS{1'b1}};

   phase_type             phase_ff,    phase_in;
   logic [DELAY_BITS-1:0] counter_ff,  counter_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  held_sel_ff, held_sel_in;
   logic [2:0]            init_pos_ff, init_pos_in;
   logic [3:0]            nibble_ff,   nibble_in;
   logic                  strobe_ff,   strobe_in;

   logic                  busy;
   logic                  rejected;
   logic [CFG_BITS-1:0]   eh_raw;
   logic [DELAY_BITS-1:0] eh_time;
   logic [DELAY_BITS-1:0] settle_time;
   logic [DELAY_BITS-1:0] powerup_time;
   logic [7:0]            next_cmd;

   // saturate a register value at the counter maximum
   function automatic logic [DELAY_BITS-1:0] clamp_time(input logic [CFG_BITS-1:0] t);
      logic [CW-1:0] ext;
      ext = CW'(t);
      if (ext > CW'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return DELAY_BITS'(ext);
   endfunction

   assign busy         = phase_ff != PH_IDLE;
   assign eh_raw       = (cfg.enable_high_ticks == '0) ? CFG_BITS'(1)
                                                       : cfg.enable_high_ticks;
   assign eh_time      = clamp_time(eh_raw);
   assign settle_time  = clamp_time(held_sel_ff ? cfg.data_settle_ticks
                                                : cfg.command_settle_ticks);
   assign powerup_time = clamp_time(cfg.powerup_ticks);
   assign next_cmd     = init_cmd(init_pos_ff);

   always_comb begin
      phase_in     = phase_ff;
      counter_in   = counter_ff;
      held_byte_in = held_byte_ff;
      held_sel_in  = held_sel_ff;
      init_pos_in  = init_pos_ff;
      nibble_in    = nibble_ff;
      strobe_in    = strobe_ff;
      rejected     = 1'b0;

      priority if (item.opcode == OP_TICK) begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_POWERUP: begin
               if (counter_ff != '0) begin
                  counter_in = counter_ff - DELAY_BITS'(1);
               end else begin
                  init_pos_in  = 3'd1;
                  held_byte_in = init_cmd(3'd0);
                  held_sel_in  = 1'b0;
                  nibble_in    = held_byte_in[7:4];
                  strobe_in    = 1'b1;
                  counter_in   = eh_time;
                  phase_in     = PH_HI_EN;
               end
            end
            PH_HI_EN, PH_LO_EN: begin
               if (counter_ff > DELAY_BITS'(1)) begin
                  counter_in = counter_ff - DELAY_BITS'(1);
               end else begin
                  strobe_in  = 1'b0;
                  counter_in = settle_time;
                  phase_in   = (phase_ff == PH_HI_EN) ? PH_HI_SET : PH_LO_SET;
               end
            end
            PH_HI_SET: begin
               if (counter_ff != '0) begin
                  counter_in = counter_ff - DELAY_BITS'(1);
               end else begin
                  nibble_in  = held_byte_ff[3:0];
                  strobe_in  = 1'b1;
                  counter_in = eh_time;
                  phase_in   = PH_LO_EN;
               end
            end
            PH_LO_SET: begin
               priority if (counter_ff != '0) begin
                  counter_in = counter_ff - DELAY_BITS'(1);
               end else if (init_pos_ff >= 3'd1 && init_pos_ff <= 3'd4) begin
                  init_pos_in  = init_pos_ff + 3'd1;
                  held_byte_in = next_cmd;
                  held_sel_in  = 1'b0;
                  nibble_in    = next_cmd[7:4];
                  strobe_in    = 1'b1;
                  counter_in   = eh_time;
                  phase_in     = PH_HI_EN;
               end else begin
                  init_pos_in = 3'd0;
                  counter_in  = '0;
                  phase_in    = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (busy) begin
         rejected = 1'b1;
      end else if (item.opcode == OP_COMMAND || item.opcode == OP_DATA) begin
         init_pos_in  = 3'd0;
         held_byte_in = item.value_byte;
         held_sel_in  = (item.opcode == OP_DATA);
         nibble_in    = item.value_byte[7:4];
         strobe_in    = 1'b1;
         counter_in   = eh_time;
         phase_in     = PH_HI_EN;
      end else begin
         held_sel_in = 1'b0;
         strobe_in   = 1'b0;
         init_pos_in = 3'd0;
         counter_in  = powerup_time;
         phase_in    = PH_POWERUP;
      end
   end

   assign result.bus_nibble  = nibble_in;
   assign result.reg_select  = held_sel_in;
   assign result.enable_line = strobe_in;
   assign result.busy_res    = phase_in != PH_IDLE;
   assign result.rejected    = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         counter_ff   <= '0;
         held_byte_ff <= '0;
         held_sel_ff  <= 1'b0;
         init_pos_ff  <= '0;
         nibble_ff    <= '0;
         strobe_ff    <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         counter_ff   <= counter_in;
         held_byte_ff <= held_byte_in;
         held_sel_ff  <= held_sel_in;
         init_pos_ff  <= init_pos_in;
         nibble_ff    <= nibble_in;
         strobe_ff    <= strobe_in;
      end
   end

   a_strobe_in_enable_phase: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (phase_ff == PH_HI_EN || phase_ff == PH_LO_EN))
      else $error("strobe high outside an enable phase");

   a_enable_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HI_EN || phase_ff == PH_LO_EN) |-> counter_ff != '0)
      else $error("enable phase with empty counter");

   a_init_pos_in_transfer: assert property (@(posedge clock) disable iff (reset)
      (init_pos_ff != '0) |-> (phase_ff != PH_IDLE && phase_ff != PH_POWERUP))
      else $error("init position set outside a transfer");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (step && rejected) |=> ($stable(phase_ff) && $stable(counter_ff)
                              && $stable(nibble_ff) && $stable(strobe_ff)))
      else $error("rejected item changed the state");

   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      rejected |-> (result.busy_res && item.opcode != OP_TICK))
      else $error("reject flagged while idle or on a tick");

endmodule
